[hdl/sla_pkg.sv]
// Shared types and constants of the segment list allocator.
`timescale 1ns / 1ps
`default_nettype none
package sla_pkg;

    localparam int NUM_SEGS  = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int START_W   = 7;
    localparam int SIZE_W    = 8;
    localparam int OWNER_W   = 8;
    localparam int HEAP_SIZE = 128;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [IDX_W-1:0] seg_idx_t;

    // One segment table entry.
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
        logic               busy;
        logic [OWNER_W-1:0] owner;
    } seg_entry_t;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_ROTATE,
        CO_MARK,
        CO_SPLIT,
        CO_CLEAR,
        CO_DELETE
    } cell_op_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        cell_op_t           op;
        seg_idx_t           pos;
        logic [SIZE_W-1:0]  size;
        logic [OWNER_W-1:0] owner;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_BADSIZE  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_MERGE_NEXT,
        S_MERGE_PREV,
        S_DONE
    } ctrl_state_t;

endpackage
`default_nettype wire

[hdl/segment_list_allocator_unit.sv]
// Top level of the segment list allocator: controller and chain of table cells.
//
//  Channel  Direction  Handshake            Content
//  s_       in         s_tvalid/s_tready    request: op, handle, req_size
//  m_       out        m_tvalid/m_tready    result: status, seg_start, seg_size
//  cfg_     in         cfg_valid/cfg_ready  fit_policy
//
// A request goes from acceptance to the result register through the scan, which
// rotates the cell ring once past the controller, then the update state and, for a
// free, the merge states as needed; a zero-size allocate skips them all with a bad-size result.
// Reset (aresetn low, synchronous) leaves one free segment covering the heap.
// A new request is taken once the previous result has been loaded into the output
// register; a stalled result register holds the next result in the controller.
`timescale 1ns / 1ps
`default_nettype none
module segment_list_allocator_unit import sla_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // handle [7:0], req_size [15:8]
    input  wire logic [0:0]  s_tuser,   // op [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // status [2:0], seg_start [9:3], seg_size [17:10]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data
);

    cell_cmd_t  cmd;
    seg_entry_t cells [NUM_SEGS];

    // Sequencer and handshakes.
    sla_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .head_entry (cells[0]),
        .cmd        (cmd)
    );

    // Ring of cells; each sees its two neighbours.
    for (genvar i = 0; i < NUM_SEGS; i++) begin : g_cell
        sla_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_idx    (IDX_W'(i)),
            .cmd         (cmd),
            .left_entry  (cells[(i + NUM_SEGS - 1) % NUM_SEGS]),
            .right_entry (cells[(i + 1) % NUM_SEGS]),
            .entry       (cells[i])
        );
    end

endmodule
`default_nettype wire

[hdl/sla_cell.sv]
// One cell of the segment table chain, holding a single entry.
`timescale 1ns / 1ps
`default_nettype none
module sla_cell import sla_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire seg_idx_t   cell_idx,
    input  wire cell_cmd_t  cmd,
    input  wire seg_entry_t left_entry,
    input  wire seg_entry_t right_entry,
    output seg_entry_t      entry
);

    seg_entry_t       entry_reg;
    seg_entry_t       entry_next;
    logic [CNT_W-1:0] idx_w;
    logic [CNT_W-1:0] pos_w;
    logic [CNT_W-1:0] pos_plus;

    assign idx_w    = {1'b0, cell_idx};
    assign pos_w    = {1'b0, cmd.pos};
    assign pos_plus = pos_w + 1'b1;

    // Local update chosen by the broadcast command and this cell's place.
    always_comb begin
        entry_next = entry_reg;
        unique case (cmd.op)
            CO_ROTATE: begin
                entry_next = right_entry;
            end
            CO_MARK: begin
                if (idx_w == pos_w) begin
                    entry_next.busy  = 1'b1;
                    entry_next.owner = cmd.owner;
                end
            end
            CO_SPLIT: begin
                if (idx_w == pos_w) begin
                    entry_next.busy  = 1'b1;
                    entry_next.size  = cmd.size;
                    entry_next.owner = cmd.owner;
                end else if (idx_w == pos_plus) begin
                    entry_next       = left_entry;
                    entry_next.start = left_entry.start + cmd.size[START_W-1:0];
                    entry_next.size  = left_entry.size - cmd.size;
                    entry_next.busy  = 1'b0;
                end else if (idx_w > pos_plus) begin
                    entry_next = left_entry;
                end
            end
            CO_CLEAR: begin
                if (idx_w == pos_w) begin
                    entry_next.busy = 1'b0;
                end
            end
            CO_DELETE: begin
                if (idx_w + 1'b1 == pos_w) begin
                    entry_next.size = entry_reg.size + right_entry.size;
                end else if (idx_w >= pos_w) begin
                    entry_next = right_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    // After reset the first cell holds the whole heap as one free segment.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.start <= '0;
            entry_reg.size  <= (cell_idx == '0) ? SIZE_W'(HEAP_SIZE) : '0;
            entry_reg.busy  <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

[hdl/sla_ctrl.sv]
// Controller: handshakes, table scan, fit choice and update sequencing.
`timescale 1ns / 1ps
`default_nettype none
module sla_ctrl import sla_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // handle [7:0], req_size [15:8]
    input  wire logic [0:0]  s_tuser,   // op [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // status [2:0], seg_start [9:3], seg_size [17:10]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    input  wire seg_entry_t  head_entry,
    output cell_cmd_t        cmd
);

    ctrl_state_t        state_reg, state_next;
    logic [1:0]         policy_reg;
    logic               op_reg;
    logic [OWNER_W-1:0] handle_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               dup_reg;
    logic               fit_found_reg;
    seg_idx_t           fit_idx_reg;
    logic [SIZE_W-1:0]  fit_size_reg;
    logic [START_W-1:0] fit_start_reg;
    logic               match_found_reg;
    seg_idx_t           match_idx_reg;
    logic [START_W-1:0] match_start_reg;
    logic [SIZE_W-1:0]  match_size_reg;
    logic               prev_free_reg;
    logic               next_free_reg;
    logic               take_next_reg;
    logic               prev_busy_reg;
    status_t            res_status_reg;
    logic [START_W-1:0] res_start_reg;
    logic [SIZE_W-1:0]  res_size_reg;
    logic               m_valid_reg;
    logic [23:0]        m_data_reg;

    logic               accept;
    logic               in_range;
    logic               cand;
    logic               owner_hit;
    logic               take_fit;
    logic               scan_last;
    logic               bad_size_in;
    status_t            upd_status;
    logic [START_W-1:0] upd_start;
    logic [SIZE_W-1:0]  upd_size;
    logic               upd_split;
    logic               upd_mark;
    logic               out_load;

    assign accept      = s_tvalid && s_tready;
    assign bad_size_in = (s_tuser[0] == OP_ALLOC) && (s_tdata[15:8] == '0);
    assign scan_last   = (cnt_reg == CNT_W'(NUM_SEGS - 1));
    assign out_load    = (state_reg == S_DONE) && (!m_valid_reg || m_tready);
    assign cfg_ready   = 1'b1;

    // Scan of the entry now at the head of the rotating chain.
    assign in_range  = cnt_reg < count_reg;
    assign cand      = in_range && !head_entry.busy && (head_entry.size >= size_reg);
    assign owner_hit = in_range && head_entry.busy && (head_entry.owner == handle_reg);

    always_comb begin
        take_fit = 1'b0;
        unique case (policy_reg)
            POL_FIRST: take_fit = cand && !fit_found_reg;
            POL_BEST:  take_fit = cand && (!fit_found_reg || head_entry.size < fit_size_reg);
            POL_WORST: take_fit = cand && (!fit_found_reg || head_entry.size > fit_size_reg);
            default:   take_fit = 1'b0;
        endcase
    end

    // Decision once the whole table has been seen.
    always_comb begin
        upd_status = ST_OK;
        upd_start  = '0;
        upd_size   = '0;
        upd_split  = 1'b0;
        upd_mark   = 1'b0;
        if (op_reg == OP_ALLOC) begin
            priority if (dup_reg) begin
                upd_status = ST_DUP;
            end else if (!fit_found_reg) begin
                upd_status = ST_NOFIT;
            end else if (fit_size_reg == size_reg) begin
                upd_mark  = 1'b1;
                upd_start = fit_start_reg;
                upd_size  = size_reg;
            end else if (count_reg == CNT_W'(NUM_SEGS)) begin
                upd_status = ST_FULL;
            end else begin
                upd_split = 1'b1;
                upd_start = fit_start_reg;
                upd_size  = size_reg;
            end
        end else begin
            if (match_found_reg) begin
                upd_start = match_start_reg;
                upd_size  = match_size_reg;
            end else begin
                upd_status = ST_NOTFOUND;
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = bad_size_in ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                priority if (op_reg == OP_FREE && match_found_reg && next_free_reg) begin
                    state_next = S_MERGE_NEXT;
                end else if (op_reg == OP_FREE && match_found_reg && prev_free_reg) begin
                    state_next = S_MERGE_PREV;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MERGE_NEXT: begin
                state_next = prev_free_reg ? S_MERGE_PREV : S_DONE;
            end
            S_MERGE_PREV: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs: input ready and the command to the cells.
    always_comb begin
        s_tready  = (state_reg == S_IDLE);
        cmd.op    = CO_HOLD;
        cmd.pos   = '0;
        cmd.size  = size_reg;
        cmd.owner = handle_reg;
        unique case (state_reg)
            S_SCAN: begin
                cmd.op = CO_ROTATE;
            end
            S_UPDATE: begin
                if (upd_mark) begin
                    cmd.op  = CO_MARK;
                    cmd.pos = fit_idx_reg;
                end else if (upd_split) begin
                    cmd.op  = CO_SPLIT;
                    cmd.pos = fit_idx_reg;
                end else if (op_reg == OP_FREE && match_found_reg) begin
                    cmd.op  = CO_CLEAR;
                    cmd.pos = match_idx_reg;
                end
            end
            S_MERGE_NEXT: begin
                cmd.op  = CO_DELETE;
                cmd.pos = match_idx_reg + 1'b1;
            end
            S_MERGE_PREV: begin
                cmd.op  = CO_DELETE;
                cmd.pos = match_idx_reg;
            end
            default: begin
                cmd.op = CO_HOLD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            policy_reg  <= POL_FIRST;
            count_reg   <= CNT_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                policy_reg <= cfg_data;
            end
            if (state_reg == S_UPDATE && upd_split) begin
                count_reg <= count_reg + 1'b1;
            end else if (state_reg == S_MERGE_NEXT || state_reg == S_MERGE_PREV) begin
                count_reg <= count_reg - 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, scan bookkeeping and result staging.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg          <= s_tuser[0];
            handle_reg      <= s_tdata[7:0];
            size_reg        <= s_tdata[15:8];
            cnt_reg         <= '0;
            dup_reg         <= 1'b0;
            fit_found_reg   <= 1'b0;
            match_found_reg <= 1'b0;
            prev_free_reg   <= 1'b0;
            next_free_reg   <= 1'b0;
            take_next_reg   <= 1'b0;
            prev_busy_reg   <= 1'b1;
            res_status_reg  <= ST_BADSIZE;
            res_start_reg   <= '0;
            res_size_reg    <= '0;
        end else if (state_reg == S_SCAN) begin
            cnt_reg       <= cnt_reg + 1'b1;
            prev_busy_reg <= head_entry.busy;
            if (owner_hit) begin
                dup_reg <= 1'b1;
            end
            if (take_fit) begin
                fit_found_reg <= 1'b1;
                fit_idx_reg   <= cnt_reg[IDX_W-1:0];
                fit_size_reg  <= head_entry.size;
                fit_start_reg <= head_entry.start;
            end
            take_next_reg <= owner_hit && !match_found_reg;
            if (owner_hit && !match_found_reg) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= cnt_reg[IDX_W-1:0];
                match_start_reg <= head_entry.start;
                match_size_reg  <= head_entry.size;
                prev_free_reg   <= (cnt_reg != '0) && !prev_busy_reg;
            end
            if (take_next_reg) begin
                next_free_reg <= in_range && !head_entry.busy;
            end
        end else if (state_reg == S_UPDATE) begin
            res_status_reg <= upd_status;
            res_start_reg  <= upd_start;
            res_size_reg   <= upd_size;
        end
        if (out_load) begin
            m_data_reg <= {6'b0, res_size_reg, res_start_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(NUM_SEGS)))
        else $error("segment count out of range");
    a_split_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CO_SPLIT) |-> (count_reg < CNT_W'(NUM_SEGS)))
        else $error("split issued with a full table");
    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && !scan_last) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("scan counter skipped");
    a_merge_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MERGE_NEXT || state_reg == S_MERGE_PREV)
        |-> (op_reg == OP_FREE && match_found_reg))
        else $error("merge without a freed segment");
`endif

endmodule
`default_nettype wire

[test/sla_checker.sv]
// Checker for the segment list allocator: watches the channels, predicts results and compares.
`timescale 1ns / 1ps
module sla_checker import sla_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,   // handle [7:0], req_size [15:8]
    input  wire logic [0:0]  s_tuser,   // op [0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // status [2:0], seg_start [9:3], seg_size [17:10]
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_data,
    output int               fail_count,
    output int               waiting
);

    typedef struct packed {
        status_t            st;
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
    } alloc_result_t;

    // Shadow copy of the segment table and the fit policy.
    logic [START_W-1:0] tab_start [NUM_SEGS];
    logic [SIZE_W-1:0]  tab_size  [NUM_SEGS];
    logic               tab_busy  [NUM_SEGS];
    logic [OWNER_W-1:0] tab_owner [NUM_SEGS];
    int                 seg_total;
    logic [1:0]         policy;

    alloc_result_t result_q[$];
    int            errs;

    task automatic clear_table();
        for (int i = 0; i < NUM_SEGS; i++) begin
            tab_start[i] = '0;
            tab_size[i]  = '0;
            tab_busy[i]  = 1'b0;
            tab_owner[i] = '0;
        end
        tab_size[0] = SIZE_W'(HEAP_SIZE);
        seg_total   = 1;
        policy      = POL_FIRST;
    endtask

    // Collapse every run of neighbouring free segments into one.
    function automatic void coalesce();
        int w;
        w = 0;
        for (int r = 0; r < seg_total; r++) begin
            if (w > 0 && !tab_busy[w-1] && !tab_busy[r]) begin
                tab_size[w-1] = tab_size[w-1] + tab_size[r];
            end else begin
                tab_start[w] = tab_start[r];
                tab_size[w]  = tab_size[r];
                tab_busy[w]  = tab_busy[r];
                tab_owner[w] = tab_owner[r];
                w++;
            end
        end
        seg_total = w;
    endfunction

    function automatic alloc_result_t err_result(status_t st);
        alloc_result_t res;
        res.st    = st;
        res.start = '0;
        res.size  = '0;
        return res;
    endfunction

    // Apply one request to the shadow table and return what the block should answer.
    function automatic alloc_result_t apply_request(logic op, logic [7:0] h, logic [7:0] sz);
        alloc_result_t res;
        int            pick;
        int            pick_sz;
        bit            found;
        logic [START_W-1:0] base;
        pick = 0;
        pick_sz = 0;
        found = 1'b0;
        if (op == OP_FREE) begin
            for (int i = 0; i < seg_total; i++) begin
                if (tab_busy[i] && tab_owner[i] == h) begin
                    res.st    = ST_OK;
                    res.start = tab_start[i];
                    res.size  = tab_size[i];
                    tab_busy[i] = 1'b0;
                    coalesce();
                    return res;
                end
            end
            return err_result(ST_NOTFOUND);
        end
        if (sz == 0)
            return err_result(ST_BADSIZE);
        for (int i = 0; i < seg_total; i++)
            if (tab_busy[i] && tab_owner[i] == h)
                return err_result(ST_DUP);
        // Choose the segment according to the fit policy, ties to the lowest index.
        for (int i = 0; i < seg_total; i++) begin
            if (tab_busy[i] || tab_size[i] < sz)
                continue;
            if (policy == POL_FIRST) begin
                if (!found) begin
                    pick = i;
                    found = 1'b1;
                end
            end else if (policy == POL_BEST) begin
                if (!found || tab_size[i] < pick_sz) begin
                    pick = i;
                    pick_sz = tab_size[i];
                    found = 1'b1;
                end
            end else if (policy == POL_WORST) begin
                if (!found || tab_size[i] > pick_sz) begin
                    pick = i;
                    pick_sz = tab_size[i];
                    found = 1'b1;
                end
            end
        end
        if (!found)
            return err_result(ST_NOFIT);
        base = tab_start[pick];
        res.st    = ST_OK;
        res.start = base;
        res.size  = sz;
        if (tab_size[pick] == sz) begin
            tab_busy[pick]  = 1'b1;
            tab_owner[pick] = h;
            return res;
        end
        if (seg_total >= NUM_SEGS)
            return err_result(ST_FULL);
        // Split: shift the tail up and put the free remainder after the new segment.
        for (int i = seg_total; i > pick; i--) begin
            tab_start[i] = tab_start[i-1];
            tab_size[i]  = tab_size[i-1];
            tab_busy[i]  = tab_busy[i-1];
            tab_owner[i] = tab_owner[i-1];
        end
        tab_start[pick+1] = base + START_W'(sz);
        tab_size[pick+1]  = tab_size[pick+1] - sz;
        tab_busy[pick+1]  = 1'b0;
        tab_size[pick]    = sz;
        tab_busy[pick]    = 1'b1;
        tab_owner[pick]   = h;
        seg_total++;
        return res;
    endfunction

    // Track beats on all three channels.
    always @(posedge aclk) begin
        alloc_result_t want;
        alloc_result_t got;
        if (!aresetn) begin
            clear_table();
            result_q.delete();
            errs = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                policy = cfg_data;
            if (s_tvalid && s_tready)
                result_q.push_back(apply_request(s_tuser[0], s_tdata[7:0], s_tdata[15:8]));
            if (m_tvalid && m_tready) begin
                got.st    = status_t'(m_tdata[2:0]);
                got.start = m_tdata[9:3];
                got.size  = m_tdata[17:10];
                if (result_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: result beat with nothing outstanding: %s%0d %0d %0d",
                                 $realtime, "st/start/size=", got.st, got.start, got.size);
                end else begin
                    want = result_q.pop_front();
                    if (want.st != got.st || want.start != got.start ||
                        want.size != got.size) begin
                        errs++;
                        if (errs <= 10)
                            $display("%0t: mismatch: expected st=%0d start=%0d size=%0d,",
                                     $realtime, want.st, want.start, want.size,
                                     " got st=%0d start=%0d size=%0d",
                                     got.st, got.start, got.size);
                    end
                end
            end
        end
        fail_count <= errs;
        waiting    <= result_q.size();
    end

endmodule

[test/tb_segment_list_allocator_unit.sv]
// Testbench top for the segment list allocator: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_segment_list_allocator_unit;
    import sla_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int POOL = 48;
    localparam int RANDOM_ITEMS = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // handle [7:0], req_size [15:8]
    logic [0:0]  s_tuser = '0;   // op [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // status [2:0], seg_start [9:3], seg_size [17:10]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = '0;

    int fail_count;
    int waiting;
    int n_sent = 0;
    int n_cfg = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    always #5 aclk = ~aclk;

    segment_list_allocator_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    sla_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .waiting(waiting)
    );

    // Watchdog: give up after a long stretch with no beat on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: changing stall patterns, and one long hold-off to back the block up.
    initial begin
        int rx_cyc;
        int mode;
        bit held;
        rx_cyc = 0;
        mode = 0;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && rx_cyc >= 4000) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (500) @(posedge aclk);
            end
            if (rx_cyc % 250 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_cyc / 37) % 2 == 0);
            endcase
            @(posedge aclk);
            rx_cyc++;
        end
    end

    // Offer one request beat and hold it until taken; then maybe open a gap.
    task automatic push_req(logic op, logic [7:0] h, logic [7:0] sz);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {sz, h};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Let every outstanding result drain, then write the fit policy.
    task automatic set_policy(logic [1:0] pol);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= pol;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    function automatic logic [7:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)  return 8'd0;
        if (r < 6)  return 8'($urandom_range(129, 255));
        if (r < 20) return 8'($urandom_range(17, 128));
        return 8'($urandom_range(1, 16));
    endfunction

    // Random mix of allocates and frees over a small handle pool, then a fill to the table limit.
    task automatic random_phase(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                push_req(OP_ALLOC, 8'($urandom_range(0, POOL - 1)), pick_size());
            else if (r < 58)
                push_req(OP_ALLOC, 8'($urandom_range(0, 255)), pick_size());
            else if (r < 95)
                push_req(OP_FREE, 8'($urandom_range(0, POOL - 1)), 8'($urandom_range(0, 255)));
            else
                push_req(OP_FREE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        for (int h = 0; h < POOL; h++)
            push_req(OP_FREE, 8'(h), 8'($urandom_range(0, 255)));
        // Many one- and two-byte allocations overflow the segment table.
        for (int h = 180; h < 246; h++)
            push_req(OP_ALLOC, 8'(h), 8'($urandom_range(1, 2)));
        for (int h = 180; h < 246; h++)
            push_req(OP_FREE, 8'(h), 8'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [1:0] pols [4];
        pols = '{POL_BEST, POL_WORST, 2'd3, POL_FIRST};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes and each special case but a full table, under first fit.
        push_req(OP_ALLOC, 8'h00, 8'd0);
        push_req(OP_ALLOC, 8'hFF, 8'd128);
        push_req(OP_ALLOC, 8'h01, 8'd1);
        push_req(OP_ALLOC, 8'hFF, 8'd5);
        push_req(OP_FREE,  8'hFF, 8'hFF);
        push_req(OP_FREE,  8'h33, 8'h00);
        push_req(OP_ALLOC, 8'h00, 8'd255);
        push_req(OP_ALLOC, 8'hAA, 8'd16);
        push_req(OP_ALLOC, 8'h55, 8'd32);
        push_req(OP_ALLOC, 8'h0F, 8'd8);
        push_req(OP_ALLOC, 8'hF0, 8'd72);
        push_req(OP_FREE,  8'h55, 8'd0);
        push_req(OP_ALLOC, 8'h77, 8'd20);
        push_req(OP_ALLOC, 8'h11, 8'd12);
        push_req(OP_FREE,  8'hAA, 8'd0);
        push_req(OP_FREE,  8'h0F, 8'd0);
        push_req(OP_FREE,  8'h11, 8'd0);
        push_req(OP_FREE,  8'h77, 8'd0);
        push_req(OP_FREE,  8'hF0, 8'd0);

        random_phase(RANDOM_ITEMS);
        foreach (pols[p]) begin
            set_policy(pols[p]);
            random_phase(RANDOM_ITEMS);
        end

        // Drain, then allow the block its full latency before the verdict.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d requests across %0d policy writes (first, best, worst and unused fit),",
                 n_sent, n_cfg);
        $display("with table overflow, duplicate, unknown-owner and bad-size requests.");
        if (fail_count == 0 && waiting == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failures, %0d results missing", fail_count, waiting);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
